/* hw/rtl/hlt_pkg.sv */
// ----------------------------------------------------------------------------
// hlt_pkg
// Shared types and constants for the heartbeat liveness table: item and
// result beats, the stored entry row, status codes and reset values.
// ----------------------------------------------------------------------------
package hlt_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam logic [3:0] MISS_LIMIT_RST = 4'd3;
  localparam logic [3:0] MISS_SAT       = 4'd15;

  localparam logic FUNC_MSG  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [2:0] ST_PARENT_CHANGED = 3'd0;
  localparam logic [2:0] ST_PARENT_SAME    = 3'd1;
  localparam logic [2:0] ST_NEW_ENTRY      = 3'd2;
  localparam logic [2:0] ST_REUSED         = 3'd3;
  localparam logic [2:0] ST_REJECTED       = 3'd4;
  localparam logic [2:0] ST_TICK           = 3'd5;

  typedef struct packed {
    logic        func;
    logic [63:0] sender_hi;
    logic [63:0] sender_lo;
    logic [63:0] parent_hi;
    logic [63:0] parent_lo;
  } hlt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [15:0] alive_mask;
    logic [4:0]  client_count;
  } hlt_out_t;

  typedef struct packed {
    logic [63:0] node_hi;
    logic [63:0] node_lo;
    logic [63:0] parent_hi;
    logic [63:0] parent_lo;
    logic [3:0]  miss;
    logic        heard;
  } hlt_row_t;

endpackage

/* hw/rtl/hlt_entry_ram.sv */
// ----------------------------------------------------------------------------
// hlt_entry_ram
// Entry store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module hlt_entry_ram #(
  parameter int unsigned ENTRIES = hlt_pkg::ENTRIES_DEF,
  localparam int unsigned AW     = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  hlt_pkg::hlt_row_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output hlt_pkg::hlt_row_t rd_data
);

  hlt_pkg::hlt_row_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/hlt_ctrl.sv */
// ----------------------------------------------------------------------------
// hlt_ctrl
// Scan sequencer: walks the entries in use one per cycle through the entry
// store, ages them on a tick or searches for the sender on a message, then
// places an unmatched sender if a slot is free and registers the result beat.
// ----------------------------------------------------------------------------
module hlt_ctrl #(
  parameter int unsigned ENTRIES = hlt_pkg::ENTRIES_DEF,
  localparam int unsigned IW     = $clog2(ENTRIES),
  localparam int unsigned CW     = $clog2(ENTRIES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  hlt_pkg::hlt_in_t  in_data,
  input  logic [3:0]        miss_limit,
  output logic              out_valid,
  output hlt_pkg::hlt_out_t out_data,
  output logic              rd_en,
  output logic [IW-1:0]     rd_addr,
  input  hlt_pkg::hlt_row_t rd_data,
  output logic              wr_en,
  output logic [IW-1:0]     wr_addr,
  output hlt_pkg::hlt_row_t wr_data
);

  localparam int unsigned MASK_W = (ENTRIES < 16) ? ENTRIES : 16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE,
    S_RESP
  } state_t;

  state_t            state_r,     state_nxt;
  hlt_pkg::hlt_in_t  item_r,      item_nxt;
  logic [CW-1:0]     rd_idx_r,    rd_idx_nxt;
  logic              ev_vld_r,    ev_vld_nxt;
  logic [IW-1:0]     ev_idx_r,    ev_idx_nxt;
  logic              found_r,     found_nxt;
  logic              have_dead_r, have_dead_nxt;
  logic [IW-1:0]     dead_idx_r,  dead_idx_nxt;
  logic [2:0]        status_r,    status_nxt;
  logic [IW-1:0]     slot_r,      slot_nxt;
  logic [CW-1:0]     used_r,      used_nxt;
  logic [ENTRIES-1:0] alive_r,    alive_nxt;
  logic              out_valid_r, out_valid_nxt;
  hlt_pkg::hlt_out_t out_data_r,  out_data_nxt;

  hlt_pkg::hlt_row_t fill_row;
  hlt_pkg::hlt_row_t age_row;
  logic              is_tick;
  logic              match;
  logic              parent_diff;
  logic              more;
  logic [15:0]       mask;

  assign is_tick     = (item_r.func == hlt_pkg::FUNC_TICK);
  assign match       = (rd_data.node_hi == item_r.sender_hi) &&
                       (rd_data.node_lo == item_r.sender_lo);
  assign parent_diff = (rd_data.parent_hi != item_r.parent_hi) ||
                       (rd_data.parent_lo != item_r.parent_lo);
  assign more        = (rd_idx_r < used_r);

  always_comb begin
    fill_row.node_hi   = item_r.sender_hi;
    fill_row.node_lo   = item_r.sender_lo;
    fill_row.parent_hi = item_r.parent_hi;
    fill_row.parent_lo = item_r.parent_lo;
    fill_row.miss      = 4'd0;
    fill_row.heard     = 1'b1;
  end

  always_comb begin
    age_row       = rd_data;
    age_row.heard = 1'b0;
    if (!rd_data.heard && rd_data.miss != hlt_pkg::MISS_SAT) begin
      age_row.miss = rd_data.miss + 4'd1;
    end
  end

  always_comb begin
    mask = '0;
    for (int i = 0; i < MASK_W; i++) begin
      mask[i] = alive_r[i] && (CW'(i) < used_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    rd_idx_nxt    = rd_idx_r;
    ev_vld_nxt    = ev_vld_r;
    ev_idx_nxt    = ev_idx_r;
    found_nxt     = found_r;
    have_dead_nxt = have_dead_r;
    dead_idx_nxt  = dead_idx_r;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    used_nxt      = used_r;
    alive_nxt     = alive_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = rd_idx_r[IW-1:0];
    wr_en         = 1'b0;
    wr_addr       = ev_idx_r;
    wr_data       = age_row;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt      = in_data;
          rd_idx_nxt    = '0;
          ev_vld_nxt    = 1'b0;
          found_nxt     = 1'b0;
          have_dead_nxt = 1'b0;
          dead_idx_nxt  = '0;
          slot_nxt      = '0;
          status_nxt    = (in_data.func == hlt_pkg::FUNC_TICK) ?
                          hlt_pkg::ST_TICK : hlt_pkg::ST_REJECTED;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        ev_vld_nxt = 1'b0;
        if (more) begin
          rd_en      = 1'b1;
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = rd_idx_r[IW-1:0];
          rd_idx_nxt = rd_idx_r + CW'(1);
        end
        if (!more) begin
          state_nxt = S_DONE;
        end
        if (ev_vld_r) begin
          if (is_tick) begin
            wr_en = 1'b1;
            if (!rd_data.heard && age_row.miss >= miss_limit) begin
              alive_nxt[ev_idx_r] = 1'b0;
            end
          end else if (match) begin
            wr_en               = 1'b1;
            wr_data             = fill_row;
            alive_nxt[ev_idx_r] = 1'b1;
            found_nxt           = 1'b1;
            slot_nxt            = ev_idx_r;
            status_nxt          = parent_diff ? hlt_pkg::ST_PARENT_CHANGED :
                                                hlt_pkg::ST_PARENT_SAME;
            rd_en               = 1'b0;
            ev_vld_nxt          = 1'b0;
            state_nxt           = S_DONE;
          end else if (!alive_r[ev_idx_r] && !have_dead_r) begin
            have_dead_nxt = 1'b1;
            dead_idx_nxt  = ev_idx_r;
          end
        end
      end
      S_DONE: begin
        wr_data = fill_row;
        if (!is_tick && !found_r) begin
          if (used_r != CW'(ENTRIES)) begin
            wr_en                        = 1'b1;
            wr_addr                      = used_r[IW-1:0];
            alive_nxt[used_r[IW-1:0]]    = 1'b1;
            slot_nxt                     = used_r[IW-1:0];
            used_nxt                     = used_r + CW'(1);
            status_nxt                   = hlt_pkg::ST_NEW_ENTRY;
          end else if (have_dead_r) begin
            wr_en                  = 1'b1;
            wr_addr                = dead_idx_r;
            alive_nxt[dead_idx_r]  = 1'b1;
            slot_nxt               = dead_idx_r;
            status_nxt             = hlt_pkg::ST_REUSED;
          end else begin
            slot_nxt   = '0;
            status_nxt = hlt_pkg::ST_REJECTED;
          end
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.status       = status_r;
        out_data_nxt.slot         = 4'(slot_r);
        out_data_nxt.alive_mask   = mask;
        out_data_nxt.client_count = 5'(used_r);
        state_nxt                 = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ev_vld_r    <= 1'b0;
      used_r      <= '0;
      alive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ev_vld_r    <= ev_vld_nxt;
      used_r      <= used_nxt;
      alive_r     <= alive_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r      <= item_nxt;
    rd_idx_r    <= rd_idx_nxt;
    ev_idx_r    <= ev_idx_nxt;
    found_r     <= found_nxt;
    have_dead_r <= have_dead_nxt;
    dead_idx_r  <= dead_idx_nxt;
    status_r    <= status_nxt;
    slot_r      <= slot_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(ENTRIES))
    else $error("entry count beyond table size");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write of the same entry in one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result strobe while scan in progress");
`endif

endmodule

/* hw/rtl/heartbeat_liveness_table_core.sv */
// ----------------------------------------------------------------------------
// heartbeat_liveness_table_core
// Liveness table for up to ENTRIES clients: message beats refresh or place
// a sender, tick beats age every entry in use.
// ----------------------------------------------------------------------------
// Timing: a scan reads the entries in use (or up to the match) one per
//   cycle from the entry store, then steps through S_DONE and S_RESP.
// Accept: a new start beat is taken only while idle, not before the last
//   result strobe; busy drops in the strobe cycle.
// Reset: table empty, miss_limit 3; no clearing pass. Results cannot stall.
// ----------------------------------------------------------------------------
module heartbeat_liveness_table_core #(
  parameter int unsigned ENTRIES = hlt_pkg::ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  hlt_pkg::hlt_in_t  in_data,
  output logic              out_valid,
  output hlt_pkg::hlt_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_data
);

  localparam int unsigned IW = $clog2(ENTRIES);

  logic [3:0]        miss_limit_r;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  hlt_pkg::hlt_row_t rd_data;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  hlt_pkg::hlt_row_t wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_limit_r <= hlt_pkg::MISS_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      miss_limit_r <= cfg_data;
    end
  end

  hlt_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .miss_limit (miss_limit_r),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  hlt_entry_ram #(
    .ENTRIES (ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule
